FILE: sv/assert_macros.svh
// assertion helpers included by tsf_dp
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property p must hold at every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, p, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (p)) else $error(msg);

// antecedent a implies consequent c in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

FILE: sv/tsf_pkg.sv
package tsf_pkg;

  localparam int PanelW = 64;
  localparam int PanelH = 32;
  localparam int MaxResults = 32;
  localparam int RowW = $clog2(PanelH);
  localparam int CntW = $clog2(MaxResults + 1);
  // coordinates after accumulation: 10-bit values, sums up to 1023*1023
  localparam int CoordW = 11;
  localparam int AccW = 22;
  localparam int DivW = 22;

  localparam logic FUNC_DRAW  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SORT,
    ST_SETUP,
    ST_ROW,
    ST_DIV,
    ST_READ,
    ST_EMIT,
    ST_NEXT
  } tsf_state_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic setup;
    logic row_start;
    logic div_start;
    logic mem_read;
    logic emit;
    logic step;
    logic clear;
  } tsf_cmd_t;

  typedef struct packed {
    logic flat;
    logic done;
    logic visible;
    logic div_busy;
    logic clear_done;
  } tsf_sts_t;

endpackage

FILE: sv/tsf_if.sv
interface tsf_in_if;
  import tsf_pkg::*;
  logic valid;
  logic ready;
  logic func;
  logic signed [9:0] v0_x;
  logic signed [9:0] v0_y;
  logic signed [9:0] v1_x;
  logic signed [9:0] v1_y;
  logic signed [9:0] v2_x;
  logic signed [9:0] v2_y;
  logic [15:0] tri_color;
  modport source (output valid, func, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, tri_color,
                  input ready);
  modport sink (input valid, func, v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, tri_color,
                output ready);
endinterface

interface tsf_out_if;
  logic valid;
  logic ready;
  logic [4:0] row;
  logic [63:0] pixel_mask;
  logic [15:0] pixel_color;
  logic last;
  modport source (output valid, row, pixel_mask, pixel_color, last, input ready);
  modport sink (input valid, row, pixel_mask, pixel_color, last, output ready);
endinterface

FILE: sv/tsf_ram.sv
module tsf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/tsf_div.sv
// restoring signed divider, truncating toward zero, one quotient bit a cycle
module tsf_div import tsf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [AccW-1:0] num,
  input  logic signed [CoordW-1:0] den,
  output logic                   busy,
  output logic signed [AccW-1:0] quo
);
  localparam int CW = $clog2(DivW + 1);
  logic [DivW-1:0] rem_r, rem_nxt, q_r, q_nxt;
  logic [CoordW-1:0] d_r, d_nxt;
  logic neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DivW:0] trial;
  logic [DivW-1:0] shifted;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    d_nxt = d_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    shifted = '0;
    trial = '0;
    if (start) begin
      q_nxt = num[AccW-1] ? DivW'(-num) : DivW'(num);
      d_nxt = den[CoordW-1] ? CoordW'(-den) : CoordW'(den);
      neg_nxt = num[AccW-1] ^ den[CoordW-1];
      rem_nxt = '0;
      cnt_nxt = CW'(DivW);
    end else if (cnt_r != '0) begin
      shifted = {rem_r[DivW-2:0], q_r[DivW-1]};
      trial = {1'b0, shifted} - {{(DivW+1-CoordW){1'b0}}, d_r};
      if (!trial[DivW]) begin
        rem_nxt = trial[DivW-1:0];
        q_nxt = {q_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

FILE: sv/tsf_dp.sv
module tsf_dp import tsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  tsf_cmd_t cmd,
  output tsf_sts_t sts,
  tsf_in_if.sink   in_ch,
  tsf_out_if.source out_ch
);
  `include "assert_macros.svh"

  logic signed [CoordW-1:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic signed [CoordW-1:0] x0_nxt, y0_nxt, x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic [15:0] col_r;
  logic [15:0] pcol_r;
  logic last_r, last_nxt;
  logic signed [CoordW-1:0] y_r, lastr_r;
  logic lower_r;
  logic signed [AccW-1:0] sa_r, sb_r;
  logic signed [CoordW-1:0] a_r, b_r;
  logic [CntW-1:0] n_r;
  logic [RowW-1:0] clr_r;
  logic divsel_r;
  logic signed [AccW-1:0] dnum;
  logic signed [CoordW-1:0] dden;
  logic dbusy;
  logic signed [AccW-1:0] dq;
  logic [PanelW-1:0] rdata, span;
  logic [63:0] mask_r;
  logic [RowW-1:0] row_r;
  logic ov_r;
  logic signed [CoordW-1:0] dy01, dy02, dy12, dx01, dx02, dx12;
  logic signed [CoordW-1:0] lo, hi;
  logic signed [CoordW-1:0] t_x, t_y;
  logic we;
  logic [RowW-1:0] waddr;
  logic [PanelW-1:0] wdata;

  assign dx01 = x1_r - x0_r;
  assign dy01 = y1_r - y0_r;
  assign dx02 = x2_r - x0_r;
  assign dy02 = y2_r - y0_r;
  assign dx12 = x2_r - x1_r;
  assign dy12 = y2_r - y1_r;

  // three-compare network, one swap per cycle would do but values are narrow
  always_comb begin
    x0_nxt = x0_r; y0_nxt = y0_r; x1_nxt = x1_r;
    y1_nxt = y1_r; x2_nxt = x2_r; y2_nxt = y2_r;
    t_x = '0; t_y = '0;
    if (y0_nxt > y1_nxt) begin
      t_x = x0_nxt; t_y = y0_nxt; x0_nxt = x1_nxt; y0_nxt = y1_nxt;
      x1_nxt = t_x; y1_nxt = t_y;
    end
    if (y0_nxt > y2_nxt) begin
      t_x = x0_nxt; t_y = y0_nxt; x0_nxt = x2_nxt; y0_nxt = y2_nxt;
      x2_nxt = t_x; y2_nxt = t_y;
    end
    if (y1_nxt > y2_nxt) begin
      t_x = x1_nxt; t_y = y1_nxt; x1_nxt = x2_nxt; y1_nxt = y2_nxt;
      x2_nxt = t_x; y2_nxt = t_y;
    end
  end

  // divider is shared between the a edge and the b edge of the current row
  always_comb begin
    if (!divsel_r) begin
      dnum = sa_r;
      dden = lower_r ? dy12 : dy01;
    end else begin
      dnum = sb_r;
      dden = dy02;
    end
  end

  tsf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dq)
  );

  always_comb begin
    lo = (a_r > b_r) ? b_r : a_r;
    hi = (a_r > b_r) ? a_r : b_r;
    if (lo < 0) lo = '0;
    if (hi > CoordW'(PanelW - 1)) hi = CoordW'(PanelW - 1);
    span = '0;
    for (int i = 0; i < PanelW; i++) begin
      span[i] = (CoordW'(i) >= lo) && (CoordW'(i) <= hi);
    end
  end

  assign we = cmd.clear || cmd.emit;
  assign waddr = cmd.clear ? clr_r : y_r[RowW-1:0];
  assign wdata = cmd.clear ? '0 : (rdata | span);

  tsf_ram #(.Width(PanelW), .Depth(PanelH)) u_occ (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(y_r[RowW-1:0]), .rdata(rdata)
  );

  // no later row can be emitted once the walk, the panel or the result budget ends
  assign last_nxt = sts.flat || sts.done || (y_r >= CoordW'(PanelH - 1)) ||
                    (n_r == CntW'(MaxResults - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      n_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.load) begin
        n_r <= '0;
        clr_r <= '0;
      end else if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.emit) begin
        ov_r <= 1'b1;
        n_r <= n_r + 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= CoordW'(in_ch.v0_x); y0_r <= CoordW'(in_ch.v0_y);
      x1_r <= CoordW'(in_ch.v1_x); y1_r <= CoordW'(in_ch.v1_y);
      x2_r <= CoordW'(in_ch.v2_x); y2_r <= CoordW'(in_ch.v2_y);
      col_r <= in_ch.tri_color;
    end
    if (cmd.sort) begin
      x0_r <= x0_nxt; y0_r <= y0_nxt; x1_r <= x1_nxt;
      y1_r <= y1_nxt; x2_r <= x2_nxt; y2_r <= y2_nxt;
    end
    if (cmd.setup) begin
      y_r <= y0_r;
      lastr_r <= (y1_r == y2_r) ? y1_r : y1_r - 1'b1;
      // with a flat top the walk starts on the lower edge
      lower_r <= (y0_r == y1_r);
      sa_r <= '0;
      sb_r <= '0;
    end
    if (cmd.row_start) begin
      divsel_r <= 1'b0;
      if (sts.flat) begin
        a_r <= (x0_r < x1_r) ? ((x0_r < x2_r) ? x0_r : x2_r) : ((x1_r < x2_r) ? x1_r : x2_r);
        b_r <= (x0_r > x1_r) ? ((x0_r > x2_r) ? x0_r : x2_r) : ((x1_r > x2_r) ? x1_r : x2_r);
      end
    end
    if (cmd.div_start && divsel_r) begin
      // first quotient ready
      a_r <= (lower_r ? x1_r : x0_r) +
             (((lower_r ? dy12 : dy01) == '0) ? CoordW'(0) : CoordW'(dq));
    end
    if (cmd.div_start) begin
      divsel_r <= ~divsel_r;
    end
    if (cmd.mem_read) begin
      b_r <= x0_r + CoordW'(dq);
    end
    if (cmd.emit) begin
      row_r <= y_r[RowW-1:0];
      mask_r <= 64'(span & ~rdata);
      pcol_r <= col_r;
      last_r <= last_nxt;
    end
    if (cmd.step) begin
      if (!lower_r && y_r == lastr_r) begin
        lower_r <= 1'b1;
        sa_r <= '0;
        sb_r <= sb_r + AccW'(dx02);
      end else begin
        sa_r <= sa_r + AccW'(lower_r ? dx12 : dx01);
        sb_r <= sb_r + AccW'(dx02);
      end
      y_r <= y_r + 1'b1;
    end
  end

  // the a edge of each row is divided before divsel flips, so capture it
  // from the first division when the second starts
  assign sts.flat = (y0_r == y2_r);
  assign sts.done = (y_r >= y2_r);
  assign sts.visible = (y_r >= 0) && (y_r < CoordW'(PanelH)) && (n_r < CntW'(MaxResults));
  assign sts.div_busy = dbusy;
  assign sts.clear_done = (clr_r == RowW'(PanelH - 1));

  assign out_ch.valid = ov_r;
  assign out_ch.row = 5'(row_r);
  assign out_ch.pixel_mask = mask_r;
  assign out_ch.pixel_color = pcol_r;
  assign out_ch.last = last_r;

  `ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, ov_r, "emit did not raise valid")
  `ASSERT_CLK(a_no_overrun, clk, rst_n, !(cmd.emit && ov_r && !out_ch.ready),
    "result overwritten")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid,
    "result dropped before acceptance")
endmodule

FILE: sv/tsf_ctrl.sv
module tsf_ctrl import tsf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  input  logic     out_free,
  input  tsf_sts_t sts,
  output tsf_cmd_t cmd,
  output logic     in_ready
);
  tsf_state_t st_r, st_nxt;

  // reset runs a full bitmap clear before the first transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt = (in_func == FUNC_CLEAR) ? ST_CLEAR : ST_SORT;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) st_nxt = ST_IDLE;
      end
      ST_SORT: begin
        cmd.sort = 1'b1;
        st_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        st_nxt = ST_ROW;
      end
      ST_ROW: begin
        cmd.row_start = 1'b1;
        st_nxt = sts.flat ? ST_READ : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        st_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (!sts.div_busy || sts.flat) begin
          if (!sts.flat) cmd.mem_read = 1'b1;
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.visible) begin
          cmd.step = !sts.flat;
          st_nxt = (sts.flat || sts.done) ? ST_IDLE : ST_ROW;
        end else if (out_free) begin
          cmd.emit = 1'b1;
          cmd.step = !sts.flat;
          st_nxt = (sts.flat || sts.done) ? ST_IDLE : ST_ROW;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: sv/triangle_scanline_fill.sv
// triangle transaction: load, sort and set up, then for each walked row a row start, two
// serial divisions on one divider and a bitmap write; rows off the panel skip the write;
// a flat triangle is one row with no division; output stalls hold a row in its emit step
// clear transaction: one bitmap row a cycle through the single write port
// one transaction at a time; results leave through a one-deep output register
// reset (synchronous, rst_n low) runs the bitmap clear before input is taken
module triangle_scanline_fill import tsf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  tsf_in_if.sink    in_ch,
  tsf_out_if.source out_ch
);
  tsf_cmd_t cmd;
  tsf_sts_t sts;

  tsf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_func(in_ch.func),
    .out_free(!out_ch.valid || out_ch.ready), .sts(sts), .cmd(cmd),
    .in_ready(in_ch.ready)
  );

  tsf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_ch(in_ch), .out_ch(out_ch)
  );
endmodule
